FILE: rtl/cfp_pkg.sv
// Shared types and constants of the checksummed frame parser.
// No dependencies; the core, controller, datapath and checker files import this package.
package cfp_pkg;

    localparam int MAX_RUN    = 32;
    localparam int RUN_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE  = 3'd0,
        CFG_INFO_CMD    = 3'd1,
        CFG_VERSION_CMD = 3'd2,
        CFG_INFO_SIZE   = 3'd3,
        CFG_VERSION_SIZE = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_GOOD        = 2'd0,
        ST_UNKNOWN_CMD = 2'd1,
        ST_HDR_BAD     = 2'd2,
        ST_BODY_BAD    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_START,
        S_CMD,
        S_LEN,
        S_HCHK,
        S_PAYLOAD,
        S_BCHK,
        S_RD,
        S_LD
    } t_state;

    typedef struct packed {
        logic    cap_start;
        logic    cap_cmd;
        logic    cap_len;
        logic    clr_count;
        logic    take_payload;
        logic    emit;
        t_status status;
        logic    run_start;
        logic    rd_en;
        logic    out_load;
        logic    rd_advance;
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic cmd_ok;
        logic hdr_ok;
        logic len_zero;
        logic count_done;
        logic body_ok;
        logic run_zero;
        logic run_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/cfp_if.sv
// Word channels of the frame parser: received bytes in, results out.
// Depends on nothing but the port widths of the block.
interface cfp_rx_if ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfp_res_if ();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       frame_kind;
    logic       data_valid;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic       last;

    modport source (output valid, output status, output frame_kind, output data_valid,
                    output payload_byte, output byte_index, output last, input ready);
    modport sink (input valid, input status, input frame_kind, input data_valid,
                  input payload_byte, input byte_index, input last, output ready);
endinterface

FILE: rtl/checksummed_frame_parser_core.sv
// Command and checksum words wait while a result word is stalled; an error or
// empty-frame status word appears in the cycle after the word that causes it.
// A good frame's run reads each byte from the store's registered port (S_RD) and then
// loads it when the result register frees (S_LD); no input word is taken meanwhile.
// Reset (synchronous, active low) clears the controller, configuration, frame
// registers and result valid flag; the payload store is not cleared.
module checksummed_frame_parser_core #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cfp_rx_if.sink                         i_rx,
    cfp_res_if.source                      o_res
);
    import cfp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     rx_ready;

    cfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (rx_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cfp_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx.rx_byte),
        .i_out_ready    (o_res.ready),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_res.valid),
        .o_status       (o_res.status),
        .o_frame_kind   (o_res.frame_kind),
        .o_data_valid   (o_res.data_valid),
        .o_payload_byte (o_res.payload_byte),
        .o_byte_index   (o_res.byte_index),
        .o_last         (o_res.last)
    );

    assign i_rx.ready = rx_ready;
endmodule

FILE: rtl/cfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/cfp_ctrl.sv
// Frame parser controller: walks the frame fields and sequences the payload run.
// Depends on cfp_pkg; drives cfp_dp through t_dp_cmd and reads t_dp_stat.
module cfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  cfp_pkg::t_dp_stat i_stat,
    output cfp_pkg::t_dp_cmd  o_cmd
);
    import cfp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_START;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.status = ST_GOOD;
        o_rx_ready = 1'b0;
        unique case (r_state)
            S_START, S_LEN, S_PAYLOAD: o_rx_ready = 1'b1;
            S_CMD, S_HCHK, S_BCHK:     o_rx_ready = i_stat.out_free;
            default:                   o_rx_ready = 1'b0;
        endcase
        acc = i_rx_valid && o_rx_ready;

        unique case (r_state)
            S_START: begin
                if (acc && i_stat.is_start) begin
                    o_cmd.cap_start = 1'b1;
                    n_state = S_CMD;
                end
            end
            S_CMD: begin
                if (acc) begin
                    if (i_stat.cmd_ok) begin
                        o_cmd.cap_cmd = 1'b1;
                        n_state = S_LEN;
                    end else begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_UNKNOWN_CMD;
                        n_state = S_START;
                    end
                end
            end
            S_LEN: begin
                if (acc) begin
                    o_cmd.cap_len = 1'b1;
                    n_state = S_HCHK;
                end
            end
            S_HCHK: begin
                if (acc) begin
                    if (!i_stat.hdr_ok) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_HDR_BAD;
                        n_state = S_START;
                    end else begin
                        o_cmd.clr_count = 1'b1;
                        n_state = i_stat.len_zero ? S_BCHK : S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD: begin
                if (acc) begin
                    o_cmd.take_payload = 1'b1;
                    if (i_stat.count_done) begin
                        n_state = S_BCHK;
                    end
                end
            end
            S_BCHK: begin
                if (acc) begin
                    if (!i_stat.body_ok) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_BODY_BAD;
                        n_state = S_START;
                    end else if (i_stat.run_zero) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_GOOD;
                        n_state = S_START;
                    end else begin
                        o_cmd.run_start = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_LD;
            end
            S_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.run_last) begin
                        n_state = S_START;
                    end else begin
                        o_cmd.rd_advance = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_START;
        endcase
    end
endmodule

FILE: rtl/cfp_dp.sv
// Frame parser datapath: configuration, checksums, payload store and result register.
// Depends on cfp_pkg and cfp_ram; commanded by cfp_ctrl.
module cfp_dp #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cfp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cfp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [7:0]                       i_rx_byte,
    input  logic                             i_out_ready,
    input  cfp_pkg::t_dp_cmd                 i_cmd,
    output cfp_pkg::t_dp_stat                o_stat,
    output logic                             o_out_valid,
    output logic [1:0]                       o_status,
    output logic                             o_frame_kind,
    output logic                             o_data_valid,
    output logic [7:0]                       o_payload_byte,
    output logic [4:0]                       o_byte_index,
    output logic                             o_last
);
    import cfp_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [RUN_W-1:0] KEEP_MAX =
        RUN_W'((BUF_DEPTH < MAX_RUN) ? BUF_DEPTH : MAX_RUN);

    logic [7:0]       r_start_byte;
    logic [7:0]       r_info_cmd;
    logic [7:0]       r_ver_cmd;
    logic [5:0]       r_info_size;
    logic [5:0]       r_ver_size;
    logic             r_kind;
    logic [7:0]       r_length;
    logic [7:0]       r_hsum;
    logic [7:0]       r_bsum;
    logic [7:0]       r_count;
    logic [RUN_W-1:0] r_run_len;
    logic [RUN_W-1:0] r_rd_idx;
    logic             r_out_valid;
    t_status          r_out_status;
    logic             r_out_kind;
    logic             r_out_dv;
    logic [7:0]       r_out_byte;
    logic [4:0]       r_out_idx;
    logic             r_out_last;

    logic [5:0]       size_sel;
    logic [RUN_W-1:0] keep;
    logic [RUN_W-1:0] run_n;
    logic [7:0]       next_count;
    logic [RUN_W-1:0] next_rd_idx;
    logic             store_en;
    logic [7:0]       ram_rdata;

    always_comb begin
        size_sel    = r_kind ? r_ver_size : r_info_size;
        keep        = (RUN_W'(size_sel) > KEEP_MAX) ? KEEP_MAX : RUN_W'(size_sel);
        run_n       = (r_length < 8'(keep)) ? r_length[RUN_W-1:0] : keep;
        next_count  = r_count + 8'd1;
        next_rd_idx = r_rd_idx + RUN_W'(1);
        store_en    = i_cmd.take_payload && (r_count < 8'(keep));

        o_stat.is_start   = (i_rx_byte == r_start_byte);
        o_stat.cmd_ok     = (i_rx_byte == r_info_cmd) || (i_rx_byte == r_ver_cmd);
        o_stat.hdr_ok     = ((8'd0 - r_hsum) == i_rx_byte);
        o_stat.len_zero   = (r_length == 8'd0);
        o_stat.count_done = (next_count == r_length);
        o_stat.body_ok    = ((8'd0 - r_bsum) == i_rx_byte);
        o_stat.run_zero   = (run_n == '0);
        o_stat.run_last   = (next_rd_idx == r_run_len);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
            r_info_cmd   <= '0;
            r_ver_cmd    <= '0;
            r_info_size  <= '0;
            r_ver_size   <= '0;
            r_kind       <= 1'b0;
            r_length     <= '0;
            r_hsum       <= '0;
            r_bsum       <= '0;
            r_count      <= '0;
            r_run_len    <= '0;
            r_rd_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START_BYTE:   r_start_byte <= i_cfg_data;
                    CFG_INFO_CMD:     r_info_cmd   <= i_cfg_data;
                    CFG_VERSION_CMD:  r_ver_cmd    <= i_cfg_data;
                    CFG_INFO_SIZE:    r_info_size  <= i_cfg_data[5:0];
                    CFG_VERSION_SIZE: r_ver_size   <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_cmd.cap_start) begin
                r_hsum <= i_rx_byte;
                r_bsum <= '0;
            end
            if (i_cmd.cap_cmd) begin
                r_kind <= (i_rx_byte != r_info_cmd);
                r_hsum <= r_hsum + i_rx_byte;
            end
            if (i_cmd.cap_len) begin
                r_length <= i_rx_byte;
                r_hsum   <= r_hsum + i_rx_byte;
            end
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end
            if (i_cmd.take_payload) begin
                r_bsum  <= r_bsum + i_rx_byte;
                r_count <= next_count;
            end
            if (i_cmd.run_start) begin
                r_run_len <= run_n;
                r_rd_idx  <= '0;
            end
            if (i_cmd.rd_advance) begin
                r_rd_idx <= next_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.status;
            r_out_kind   <= (i_cmd.status == ST_UNKNOWN_CMD) ? 1'b0 : r_kind;
            r_out_dv     <= 1'b0;
            r_out_byte   <= '0;
            r_out_idx    <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.out_load) begin
            r_out_status <= ST_GOOD;
            r_out_kind   <= r_kind;
            r_out_dv     <= 1'b1;
            r_out_byte   <= ram_rdata;
            r_out_idx    <= r_rd_idx[4:0];
            r_out_last   <= o_stat.run_last;
        end
    end

    cfp_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_frame_kind   = r_out_kind;
    assign o_data_valid   = r_out_dv;
    assign o_payload_byte = r_out_byte;
    assign o_byte_index   = r_out_idx;
    assign o_last         = r_out_last;
endmodule

FILE: rtl/cfp_checker.sv
// Port-level checks of the frame parser result stream, bound to the top level.
// Depends on cfp_pkg and checksummed_frame_parser_core.
module cfp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_status,
    input logic       i_frame_kind,
    input logic       i_data_valid,
    input logic [7:0] i_payload_byte,
    input logic [4:0] i_byte_index,
    input logic       i_last
);
    import cfp_pkg::*;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
        && $stable({i_status, i_frame_kind, i_data_valid, i_payload_byte,
                    i_byte_index, i_last}))
        else $error("stalled result word changed");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_data_valid || i_last)
        else $error("status word without last");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status != ST_GOOD) |-> !i_data_valid)
        else $error("error word carries payload");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_data_valid |-> (i_payload_byte == 8'd0) && (i_byte_index == 5'd0))
        else $error("status word has payload fields set");

    a_run_blocks_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && i_data_valid && !i_last |-> !i_rx_ready)
        else $error("input taken in the middle of a payload run");
endmodule

bind checksummed_frame_parser_core cfp_checker u_cfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rx_ready     (i_rx.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_frame_kind   (o_res.frame_kind),
    .i_data_valid   (o_res.data_valid),
    .i_payload_byte (o_res.payload_byte),
    .i_byte_index   (o_res.byte_index),
    .i_last         (o_res.last)
);
